// ===== rtl/spd_pkg.sv =====
// Package for the sensor packet deframer: opcodes, result status codes,
// header positions, register reset values and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package spd_pkg;

  localparam logic [15:0] SYNC_WORD_RST     = 16'hEF01;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  typedef enum logic [0:0] {
    CFG_SYNC_WORD     = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_DONE    = 2'd1,
    ST_BAD     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    POS_HUNT     = 4'd0,
    POS_START_LO = 4'd1,
    POS_ADDR0    = 4'd2,
    POS_ADDR1    = 4'd3,
    POS_ADDR2    = 4'd4,
    POS_ADDR3    = 4'd5,
    POS_KIND     = 4'd6,
    POS_LEN_HI   = 4'd7,
    POS_LEN_LO   = 4'd8,
    POS_BODY     = 4'd9
  } hdr_pos_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] timeout_ticks;
  } spd_cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  packet_kind;
    logic [31:0] device_address;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        last;
  } spd_result_t;

endpackage

// ===== rtl/spd_cfg_regs.sv =====
// Configuration registers of the sensor packet deframer.
// Depends on spd_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module spd_cfg_regs import spd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  output logic        cfg_ready,
  output spd_cfg_t    cfg
);

  logic [15:0] sync_word_r;
  logic [15:0] timeout_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r     <= SYNC_WORD_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_addr))
        CFG_SYNC_WORD:     sync_word_r     <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.sync_word     = sync_word_r;
  assign cfg.timeout_ticks = timeout_ticks_r;

endmodule

// ===== rtl/spd_core.sv =====
// Reception state and header walk of the sensor packet deframer.
// Depends on spd_pkg; produces at most one result per accepted transaction.
`timescale 1ns / 1ps

module spd_core import spd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_fire,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  input  spd_cfg_t    cfg,
  output logic        res_valid,
  output spd_result_t res
);

  logic        armed_r, armed_nxt;
  hdr_pos_t    pos_r, pos_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] body_r, body_nxt;

  logic [15:0] wait_inc;
  logic        tick_expired;
  logic [15:0] len_full;
  logic [16:0] body_inc;
  logic        body_end;
  op_t         op;

  assign op           = op_t'(opcode);
  assign wait_inc     = wait_r + 16'd1;
  assign tick_expired = wait_inc >= cfg.timeout_ticks;
  assign len_full     = {len_r[15:8], rx_byte};
  assign body_inc     = {1'b0, body_r} + 17'd1;
  assign body_end     = body_inc >= {1'b0, len_r};

  always_comb begin
    armed_nxt = armed_r;
    pos_nxt   = pos_r;
    wait_nxt  = wait_r;
    addr_nxt  = addr_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    body_nxt  = body_r;
    if (item_fire) begin
      if (op == OP_ARM) begin
        armed_nxt = 1'b1;
        pos_nxt   = POS_HUNT;
        wait_nxt  = '0;
        addr_nxt  = '0;
        kind_nxt  = '0;
        len_nxt   = '0;
        body_nxt  = '0;
      end else if (armed_r && op == OP_TICK) begin
        wait_nxt = wait_inc;
        if (tick_expired) begin
          armed_nxt = 1'b0;
        end
      end else if (armed_r && op == OP_BYTE) begin
        case (pos_r)
          POS_HUNT: begin
            if (rx_byte == cfg.sync_word[15:8]) begin
              pos_nxt = POS_START_LO;
            end
          end
          POS_START_LO: begin
            if (rx_byte != cfg.sync_word[7:0]) begin
              armed_nxt = 1'b0;
            end else begin
              pos_nxt = POS_ADDR0;
            end
          end
          POS_ADDR0, POS_ADDR1, POS_ADDR2, POS_ADDR3: begin
            addr_nxt = {addr_r[23:0], rx_byte};
            pos_nxt  = hdr_pos_t'(pos_r + 4'd1);
          end
          POS_KIND: begin
            kind_nxt = rx_byte;
            pos_nxt  = POS_LEN_HI;
          end
          POS_LEN_HI: begin
            len_nxt = {rx_byte, 8'd0};
            pos_nxt = POS_LEN_LO;
          end
          POS_LEN_LO: begin
            len_nxt = len_full;
            if (len_full == 16'd0) begin
              armed_nxt = 1'b0;
            end else begin
              pos_nxt  = POS_BODY;
              body_nxt = '0;
            end
          end
          default: begin
            if (body_end) begin
              armed_nxt = 1'b0;
            end else begin
              body_nxt = body_inc[15:0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid          = 1'b0;
    res.status         = ST_PAYLOAD;
    res.packet_kind    = kind_nxt;
    res.device_address = addr_nxt;
    res.payload_length = len_nxt;
    res.payload_byte   = 8'd0;
    res.payload_index  = 16'd0;
    res.last           = 1'b0;
    if (item_fire && armed_r) begin
      case (op)
        OP_TICK: begin
          if (tick_expired) begin
            res_valid  = 1'b1;
            res.status = ST_TIMEOUT;
            res.last   = 1'b1;
          end
        end
        OP_BYTE: begin
          case (pos_r)
            POS_START_LO: begin
              if (rx_byte != cfg.sync_word[7:0]) begin
                res_valid  = 1'b1;
                res.status = ST_BAD;
                res.last   = 1'b1;
              end
            end
            POS_LEN_LO: begin
              if (len_full == 16'd0) begin
                res_valid  = 1'b1;
                res.status = ST_BAD;
                res.last   = 1'b1;
              end
            end
            POS_BODY: begin
              res_valid         = 1'b1;
              res.status        = body_end ? ST_DONE : ST_PAYLOAD;
              res.payload_byte  = rx_byte;
              res.payload_index = body_r;
              res.last          = body_end;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      pos_r   <= POS_HUNT;
      wait_r  <= '0;
      addr_r  <= '0;
      kind_r  <= '0;
      len_r   <= '0;
      body_r  <= '0;
    end else begin
      armed_r <= armed_nxt;
      pos_r   <= pos_nxt;
      wait_r  <= wait_nxt;
      addr_r  <= addr_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      body_r  <= body_nxt;
    end
  end

endmodule

// ===== rtl/spd_out_reg.sv =====
// Result register of the sensor packet deframer; holds one result until taken.
// Depends on spd_pkg for the result struct.
`timescale 1ns / 1ps

module spd_out_reg import spd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  spd_result_t res,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output spd_result_t out_res
);

  logic        valid_r, valid_nxt;
  spd_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

// ===== rtl/sensor_packet_deframer.sv =====
// Sensor packet deframer: takes one received byte, tick or arm transaction per
// clock while in_tready is high and gives each result in the next cycle from a
// single result register. in_tready is high whenever that register is empty or
// being drained in the same cycle, so the block sustains one transaction per
// cycle; output back-pressure reaches the input combinationally through it.
// Depends on spd_pkg, spd_cfg_regs, spd_core and spd_out_reg.
`timescale 1ns / 1ps

module sensor_packet_deframer import spd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // packet_kind[7:0], device_address[39:8], payload_length[55:40],
  // payload_byte[63:56], payload_index[79:64]
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  spd_cfg_t    cfg;
  spd_result_t res;
  spd_result_t out_res;
  logic        res_valid;
  logic        can_load;
  logic        in_fire;

  assign in_tready = can_load;
  assign in_fire   = in_tvalid && in_tready;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  spd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .opcode    (in_tuser),
    .rx_byte   (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.payload_index, out_res.payload_byte, out_res.payload_length,
                      out_res.device_address, out_res.packet_kind};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

  a_end_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_TIMEOUT || out_tuser == ST_BAD || out_tuser == ST_DONE)
    |-> out_tlast)
    else $error("Ending status without tlast.");

  a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_PAYLOAD |-> !out_tlast)
    else $error("Payload status with tlast.");

  a_error_zero_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_TIMEOUT || out_tuser == ST_BAD)
    |-> out_tdata[79:56] == 24'd0)
    else $error("Error result carries a body byte or index.");

  a_arm_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_ARM
    |=> out_tvalid == $past(out_tvalid && !out_tready))
    else $error("Arm transaction produced a result.");

endmodule
